FILE: rtl/htbd_pkg.sv
// Shared types and codes of the Huffman tree bit decoder.
package htbd_pkg;

    localparam int MODE_W     = 2;
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int CODE_W     = 32;
    localparam int CODE_IDX_W = $clog2(CODE_W);
    localparam int STATUS_W   = 3;

    // Longest code that an add accepts.
    localparam int MAX_CODE_BITS = 32;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SYMBOL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

    typedef struct packed {
        logic clear;
        logic wr_left;
        logic wr_right;
        logic wr_leaf;
    } t_store_ctl;

    typedef struct packed {
        logic missing;
        logic leaf;
    } t_step_flags;

endpackage

FILE: rtl/huffman_tree_bit_decoder.sv
// Top level of the Huffman tree bit decoder: sequencer and result register.
//
// One item is taken at a time; o_in_ready is high only while the sequencer is
// idle. Every step through the tree is one read of the node store, whose read
// data is registered, so each step has an address state and then an evaluate
// state. A decode bit steps to the child and then reads it to test for a leaf,
// ending early when the branch is missing. An add walks the existing nodes,
// then links and creates one new node per remaining bit, and writes the leaf.
// An add too long is refused at once, and one for a full store after the walk.
// The result is held in an output register, and a new result waits while that
// register is still full. The node store needs no clearing pass: a clear only
// empties the root and resets the node count and the walk, and each node is
// written when it is created.
module huffman_tree_bit_decoder
    import htbd_pkg::*;
#(
    parameter int NODE_COUNT = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SYM_W-1:0]    i_symbol,
    input  logic [LEN_W-1:0]    i_code_length,
    input  logic [CODE_W-1:0]   i_code_value,
    input  logic                i_data_bit,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SYM_W-1:0]    o_out_symbol
);

    localparam int NW        = $clog2(NODE_COUNT);
    localparam int CW        = $clog2(NODE_COUNT + 1);
    localparam int CMP_W     = ((CW > LEN_W) ? CW : LEN_W) + 1;
    localparam int LEN_CMP_W = LEN_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_WAIT,
        S_A_EVAL,
        S_A_LINK,
        S_A_NEW,
        S_A_LEAF,
        S_D_WAIT1,
        S_D_EVAL1,
        S_D_WAIT2,
        S_D_EVAL2,
        S_POST
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]       r_nodes_used, n_nodes_used;
    logic [NW-1:0]       r_walk, n_walk;
    logic [NW-1:0]       r_node, n_node;
    logic [LEN_W-1:0]    r_bits, n_bits;
    logic [CODE_W-1:0]   r_code, n_code;
    logic [SYM_W-1:0]    r_sym_in, n_sym_in;
    logic                r_bit, n_bit;
    logic [STATUS_W-1:0] r_pend_status, n_pend_status;
    logic [SYM_W-1:0]    r_pend_sym, n_pend_sym;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [SYM_W-1:0]    r_osym, n_osym;

    t_store_ctl    store_ctl;
    logic [NW-1:0] wr_left_d;
    logic [NW-1:0] wr_right_d;
    logic [NW-1:0] rd_left;
    logic [NW-1:0] rd_right;
    logic [SYM_W-1:0] rd_sym;

    logic [NW-1:0]    step_child;
    t_step_flags      step_flags;
    logic             step_bit;
    logic [LEN_W-1:0] bit_idx;
    logic             code_bit;
    logic [CMP_W-1:0] free_nodes;
    logic             in_fire;
    logic             can_post;
    logic [NW-1:0]    node_next;

    htbd_node_store #(
        .NODE_COUNT (NODE_COUNT),
        .NW         (NW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (store_ctl),
        .i_rd_addr  (r_node),
        .i_wr_addr  (r_node),
        .i_wr_left  (wr_left_d),
        .i_wr_right (wr_right_d),
        .i_wr_sym   (r_sym_in),
        .o_left     (rd_left),
        .o_right    (rd_right),
        .o_sym      (rd_sym)
    );

    htbd_step_unit #(
        .NW (NW)
    ) u_step (
        .i_left  (rd_left),
        .i_right (rd_right),
        .i_bit   (step_bit),
        .o_child (step_child),
        .o_flags (step_flags)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign can_post   = !r_out_valid || i_out_ready;

    // Code bits above the code_value field read as zero.
    assign bit_idx  = r_bits - LEN_W'(1);
    assign code_bit = (bit_idx < LEN_W'(CODE_W)) ? r_code[bit_idx[CODE_IDX_W-1:0]] : 1'b0;
    assign step_bit = (r_state == S_D_EVAL1) ? r_bit : code_bit;

    assign free_nodes = CMP_W'(NODE_COUNT) - CMP_W'(r_nodes_used);
    assign node_next  = r_node + NW'(1);

    always_comb begin
        n_state       = r_state;
        n_nodes_used  = r_nodes_used;
        n_walk        = r_walk;
        n_node        = r_node;
        n_bits        = r_bits;
        n_code        = r_code;
        n_sym_in      = r_sym_in;
        n_bit         = r_bit;
        n_pend_status = r_pend_status;
        n_pend_sym    = r_pend_sym;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_osym        = r_osym;
        store_ctl     = '0;
        wr_left_d     = '0;
        wr_right_d    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_pend_status = ST_NONE;
                    n_pend_sym    = '0;
                    unique case (i_mode)
                        MODE_CLEAR: begin
                            store_ctl.clear = 1'b1;
                            n_nodes_used    = CW'(1);
                            n_walk          = '0;
                            n_state         = S_POST;
                        end
                        MODE_ADD: begin
                            n_sym_in = i_symbol;
                            n_code   = i_code_value;
                            n_bits   = i_code_length;
                            n_node   = '0;
                            if (LEN_CMP_W'(i_code_length) > LEN_CMP_W'(MAX_CODE_BITS)) begin
                                n_pend_status = ST_TOO_LONG;
                                n_state       = S_POST;
                            end else if (i_code_length == '0) begin
                                n_state = S_A_LEAF;
                            end else begin
                                n_state = S_A_WAIT;
                            end
                        end
                        MODE_DECODE: begin
                            n_node  = r_walk;
                            n_bit   = i_data_bit;
                            n_state = S_D_WAIT1;
                        end
                        default: begin
                            n_state = S_POST;
                        end
                    endcase
                end
            end
            S_A_WAIT: begin
                n_state = S_A_EVAL;
            end
            S_A_EVAL: begin
                if (step_flags.missing) begin
                    // The remaining bits all need new nodes; check room first.
                    if (CMP_W'(r_bits) > free_nodes) begin
                        n_pend_status = ST_FULL;
                        n_state       = S_POST;
                    end else begin
                        n_state = S_A_LINK;
                    end
                end else begin
                    n_node = step_child;
                    n_bits = r_bits - LEN_W'(1);
                    n_state = (r_bits == LEN_W'(1)) ? S_A_LEAF : S_A_WAIT;
                end
            end
            S_A_LINK: begin
                store_ctl.wr_left  = !code_bit;
                store_ctl.wr_right = code_bit;
                wr_left_d          = r_nodes_used[NW-1:0];
                wr_right_d         = r_nodes_used[NW-1:0];
                n_node             = r_nodes_used[NW-1:0];
                n_bits             = r_bits - LEN_W'(1);
                n_state            = S_A_NEW;
            end
            S_A_NEW: begin
                // New nodes are allocated in order, so each one but the last links to the next.
                store_ctl.wr_left  = 1'b1;
                store_ctl.wr_right = 1'b1;
                n_nodes_used       = r_nodes_used + CW'(1);
                if (r_bits != '0) begin
                    wr_left_d  = code_bit ? '0 : node_next;
                    wr_right_d = code_bit ? node_next : '0;
                    n_node     = node_next;
                    n_bits     = r_bits - LEN_W'(1);
                end else begin
                    n_state = S_A_LEAF;
                end
            end
            S_A_LEAF: begin
                store_ctl.wr_leaf = 1'b1;
                n_state           = S_POST;
            end
            S_D_WAIT1: begin
                n_state = S_D_EVAL1;
            end
            S_D_EVAL1: begin
                if (step_flags.missing) begin
                    n_pend_status = ST_MISSING;
                    n_walk        = '0;
                    n_state       = S_POST;
                end else begin
                    n_node  = step_child;
                    n_state = S_D_WAIT2;
                end
            end
            S_D_WAIT2: begin
                n_state = S_D_EVAL2;
            end
            S_D_EVAL2: begin
                if (step_flags.leaf) begin
                    n_pend_status = ST_SYMBOL;
                    n_pend_sym    = rd_sym;
                    n_walk        = '0;
                end else begin
                    n_walk = r_node;
                end
                n_state = S_POST;
            end
            S_POST: begin
                if (can_post) begin
                    n_out_valid = 1'b1;
                    n_status    = r_pend_status;
                    n_osym      = r_pend_sym;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nodes_used <= CW'(1);
            r_walk       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_nodes_used <= n_nodes_used;
            r_walk       <= n_walk;
            r_out_valid  <= n_out_valid;
        end
        r_node        <= n_node;
        r_bits        <= n_bits;
        r_code        <= n_code;
        r_sym_in      <= n_sym_in;
        r_bit         <= n_bit;
        r_pend_status <= n_pend_status;
        r_pend_sym    <= n_pend_sym;
        r_status      <= n_status;
        r_osym        <= n_osym;
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_out_symbol = r_osym;

    // A clear transfer leaves only the root in the tree and the walk at the root.
    a_clear_resets_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_mode == MODE_CLEAR) |=> (r_nodes_used == CW'(1) && r_walk == '0))
        else $error("tree not emptied after clear");

    // The walk may only rest on a node that has been allocated.
    a_walk_in_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW'(r_walk) < r_nodes_used))
        else $error("walk node outside the allocated tree");

    // The node count never passes the store size.
    a_nodes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_NEW) |-> (r_nodes_used < CW'(NODE_COUNT)))
        else $error("node allocation beyond the store");

    // Only a symbol result carries a nonzero symbol.
    a_symbol_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_SYMBOL) |-> (o_out_symbol == '0))
        else $error("symbol driven on a non-symbol result");

endmodule

FILE: rtl/htbd_node_store.sv
// Node store: child links and leaf symbols, with the root links held in flops.
module htbd_node_store
    import htbd_pkg::*;
#(
    parameter int NODE_COUNT = 512,
    parameter int NW         = $clog2(NODE_COUNT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_store_ctl       i_ctl,
    input  logic [NW-1:0]    i_rd_addr,
    input  logic [NW-1:0]    i_wr_addr,
    input  logic [NW-1:0]    i_wr_left,
    input  logic [NW-1:0]    i_wr_right,
    input  logic [SYM_W-1:0] i_wr_sym,
    output logic [NW-1:0]    o_left,
    output logic [NW-1:0]    o_right,
    output logic [SYM_W-1:0] o_sym
);

    logic [NW-1:0]    left_mem  [NODE_COUNT];
    logic [NW-1:0]    right_mem [NODE_COUNT];
    logic [SYM_W-1:0] leaf_mem  [NODE_COUNT];

    logic [NW-1:0]    r_root_left;
    logic [NW-1:0]    r_root_right;
    logic [NW-1:0]    r_mem_left;
    logic [NW-1:0]    r_mem_right;
    logic [SYM_W-1:0] r_mem_sym;
    logic             r_rd_root;

    logic wr_root;

    assign wr_root = (i_wr_addr == '0);

    // The root is the only node that a clear must empty; every other node
    // gets both links written when it is created.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_root_left  <= '0;
            r_root_right <= '0;
        end else begin
            if (i_ctl.wr_left && wr_root) begin
                r_root_left <= i_wr_left;
            end
            if (i_ctl.wr_right && wr_root) begin
                r_root_right <= i_wr_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_left && !wr_root) begin
            left_mem[i_wr_addr] <= i_wr_left;
        end
        if (i_ctl.wr_right && !wr_root) begin
            right_mem[i_wr_addr] <= i_wr_right;
        end
        if (i_ctl.wr_leaf) begin
            leaf_mem[i_wr_addr] <= i_wr_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem_left  <= left_mem[i_rd_addr];
        r_mem_right <= right_mem[i_rd_addr];
        r_mem_sym   <= leaf_mem[i_rd_addr];
        r_rd_root   <= (i_rd_addr == '0);
    end

    assign o_left  = r_rd_root ? r_root_left  : r_mem_left;
    assign o_right = r_rd_root ? r_root_right : r_mem_right;
    assign o_sym   = r_mem_sym;

endmodule

FILE: rtl/htbd_step_unit.sv
// Tree step unit: picks the child for one code bit and tests the read node.
module htbd_step_unit
    import htbd_pkg::*;
#(
    parameter int NW = 9
) (
    input  logic [NW-1:0] i_left,
    input  logic [NW-1:0] i_right,
    input  logic          i_bit,
    output logic [NW-1:0] o_child,
    output t_step_flags   o_flags
);

    assign o_child         = i_bit ? i_right : i_left;
    assign o_flags.missing = (o_child == '0);
    assign o_flags.leaf    = (i_left == '0) && (i_right == '0);

endmodule
